// ----- rtl/core/pid_with_integral_zone_defines.svh -----
// Assertion helpers for the PID block. Both expect clk and arst_n in scope.
`ifndef PID_WITH_INTEGRAL_ZONE_DEFINES_SVH
`define PID_WITH_INTEGRAL_ZONE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PIDZ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PIDZ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/pidz_pkg.sv -----
package pidz_pkg;

	localparam int DATA_WIDTH     = 16;
	localparam int GAIN_FRAC_BITS = 8;
	localparam int ACC_WIDTH      = 32;
	localparam int COUNT_WIDTH    = 16;
	localparam int GAIN_WIDTH     = 16;
	localparam int DRIVE_WIDTH    = 32;
	localparam int REG_IDX_WIDTH  = 3;

	typedef enum logic [REG_IDX_WIDTH-1:0] {
		REG_SETPOINT,
		REG_P_GAIN,
		REG_I_GAIN,
		REG_D_GAIN,
		REG_INT_ZONE,
		REG_SETTLE_BAND,
		REG_SETTLE_TICKS
	} pidz_reg_t;

	// Gains are signed Q8.8; apply $signed at the point of use.
	typedef struct packed {
		logic [GAIN_WIDTH-1:0] p;
		logic [GAIN_WIDTH-1:0] i;
		logic [GAIN_WIDTH-1:0] d;
	} pidz_gains_t;

	typedef struct packed {
		logic load_s3;
		logic load_out;
	} pidz_ctl_t;

endpackage

// ----- rtl/core/pidz_ifs.sv -----
interface pidz_in_if #(
	parameter int DATA_WIDTH = pidz_pkg::DATA_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] measured_value;

	modport source (output valid, output measured_value, input ready);
	modport sink (input valid, input measured_value, output ready);
endinterface

interface pidz_out_if #(
	parameter int DATA_WIDTH = pidz_pkg::DATA_WIDTH
);
	logic                                   valid;
	logic                                   ready;
	logic signed [pidz_pkg::DRIVE_WIDTH-1:0] drive;
	logic signed [DATA_WIDTH:0]             error_now;
	logic                                   settled;

	modport source (output valid, output drive, output error_now, output settled, input ready);
	modport sink (input valid, input drive, input error_now, input settled, output ready);
endinterface

// ----- rtl/core/pidz_drive.sv -----
module pidz_drive #(
	parameter int DATA_WIDTH     = pidz_pkg::DATA_WIDTH,
	parameter int GAIN_FRAC_BITS = pidz_pkg::GAIN_FRAC_BITS,
	parameter int ACC_WIDTH      = pidz_pkg::ACC_WIDTH
) (
	input  logic                                    clk,
	input  pidz_pkg::pidz_ctl_t                     ctl,
	input  pidz_pkg::pidz_gains_t                   gains,
	input  logic signed [DATA_WIDTH:0]              err_s2,
	input  logic signed [DATA_WIDTH+1:0]            deriv_s2,
	input  logic signed [ACC_WIDTH-1:0]             integ_s2,
	output logic signed [pidz_pkg::DRIVE_WIDTH-1:0] drive_q
);

	localparam int GW   = pidz_pkg::GAIN_WIDTH;
	localparam int OW   = pidz_pkg::DRIVE_WIDTH;
	localparam int PW_E = DATA_WIDTH + 1 + GW;
	localparam int PW_I = ACC_WIDTH + GW;
	localparam int PW_D = DATA_WIDTH + 2 + GW;
	localparam int TW   = ((PW_I > PW_D) ? PW_I : PW_D) + 2;
	localparam int XW   = (TW > OW + 1) ? TW : OW + 1;
	localparam logic signed [XW-1:0] DMAX = {{(XW-OW+1){1'b0}}, {(OW-1){1'b1}}};
	localparam logic signed [XW-1:0] DMIN = ~DMAX;

	logic signed [PW_E-1:0] prod_e_s3;
	logic signed [PW_I-1:0] prod_i_s3;
	logic signed [PW_D-1:0] prod_d_s3;
	logic signed [TW-1:0]   total;
	logic signed [TW-1:0]   scaled;
	logic signed [XW-1:0]   scaled_x;
	logic signed [OW-1:0]   drive_d;

	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			prod_e_s3 <= err_s2 * $signed(gains.p);
			prod_i_s3 <= integ_s2 * $signed(gains.i);
			prod_d_s3 <= deriv_s2 * $signed(gains.d);
		end
	end

	// Arithmetic shift floors toward minus infinity.
	always_comb begin
		total    = TW'(prod_e_s3) + TW'(prod_i_s3) + TW'(prod_d_s3);
		scaled   = total >>> GAIN_FRAC_BITS;
		scaled_x = XW'(scaled);
		if (scaled_x > DMAX) begin
			drive_d = DMAX[OW-1:0];
		end else if (scaled_x < DMIN) begin
			drive_d = DMIN[OW-1:0];
		end else begin
			drive_d = scaled_x[OW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			drive_q <= drive_d;
		end
	end

endmodule

// ----- rtl/core/pid_with_integral_zone.sv -----
// Channel   Direction  Payload                              Handshake
// sample    in         measured_value                       valid/ready
// result    out        drive, error_now, settled            valid/ready
// wr_*      in         wr_index, wr_data                    wr_en, no back-pressure
//
// One transaction per cycle sustained while result.ready holds. Four registers in line (input
// register, error/integral stage, product stage, output register); a sample passes through
// them in that order, and result.valid is driven by the output register.
// Controller state (previous error, integral, settle count) updates in the error stage.
// arst_n clears configuration, controller state and valid flags; data registers are not reset.
// A stalled result backs up the pipeline one stage at a time; bubbles still collapse.
`include "pid_with_integral_zone_defines.svh"

module pid_with_integral_zone #(
	parameter int DATA_WIDTH     = pidz_pkg::DATA_WIDTH,
	parameter int GAIN_FRAC_BITS = pidz_pkg::GAIN_FRAC_BITS,
	parameter int ACC_WIDTH      = pidz_pkg::ACC_WIDTH,
	parameter int COUNT_WIDTH    = pidz_pkg::COUNT_WIDTH,
	localparam int CFG_WIDTH_A   = (DATA_WIDTH > pidz_pkg::GAIN_WIDTH) ?
		DATA_WIDTH : pidz_pkg::GAIN_WIDTH,
	localparam int CFG_WIDTH     = (CFG_WIDTH_A > COUNT_WIDTH) ? CFG_WIDTH_A : COUNT_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	pidz_in_if.sink                              sample,
	pidz_out_if.source                           result,
	input  logic                                 wr_en,
	input  logic [pidz_pkg::REG_IDX_WIDTH-1:0]   wr_index,
	input  logic [CFG_WIDTH-1:0]                 wr_data
);

	localparam int GW = pidz_pkg::GAIN_WIDTH;
	localparam int EW = DATA_WIDTH + 1;
	localparam int SW = ((ACC_WIDTH > EW) ? ACC_WIDTH : EW) + 1;
	localparam logic signed [SW-1:0] AMAX = {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [SW-1:0] AMIN = ~AMAX;

	// Configuration registers
	logic signed [DATA_WIDTH-1:0]  setpoint_q;
	pidz_pkg::pidz_gains_t         gains_q;
	logic [DATA_WIDTH-1:0]         int_zone_q;
	logic [DATA_WIDTH-1:0]         settle_band_q;
	logic [COUNT_WIDTH-1:0]        settle_ticks_q;

	// Controller state
	logic signed [EW-1:0]          prev_err_q;
	logic signed [ACC_WIDTH-1:0]   integ_q;
	logic [COUNT_WIDTH-1:0]        settle_count_q;

	// Pipeline
	logic                          valid_s1, valid_s2, valid_s3, out_valid_q;
	logic signed [DATA_WIDTH-1:0]  meas_s1;
	logic signed [EW-1:0]          err_s2, err_s3;
	logic signed [EW:0]            deriv_s2;
	logic signed [ACC_WIDTH-1:0]   integ_s2;
	logic                          settled_s2, settled_s3;
	logic signed [EW-1:0]          error_now_q;
	logic                          settled_q;

	logic                          rdy_out, rdy3, rdy2, rdy1, adv1;
	pidz_pkg::pidz_ctl_t           ctl;

	logic signed [EW-1:0]          err;
	logic signed [EW:0]            deriv;
	logic [EW-1:0]                 mag;
	logic signed [SW-1:0]          isum;
	logic signed [ACC_WIDTH-1:0]   integ_sat;
	logic signed [ACC_WIDTH-1:0]   integ_next;
	logic                          sign_chg;
	logic [COUNT_WIDTH-1:0]        count_next;
	logic                          settled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q     <= '0;
			gains_q        <= '0;
			int_zone_q     <= '0;
			settle_band_q  <= '0;
			settle_ticks_q <= '0;
		end else if (wr_en) begin
			unique case (pidz_pkg::pidz_reg_t'(wr_index))
				pidz_pkg::REG_SETPOINT:     setpoint_q     <= wr_data[DATA_WIDTH-1:0];
				pidz_pkg::REG_P_GAIN:       gains_q.p      <= wr_data[GW-1:0];
				pidz_pkg::REG_I_GAIN:       gains_q.i      <= wr_data[GW-1:0];
				pidz_pkg::REG_D_GAIN:       gains_q.d      <= wr_data[GW-1:0];
				pidz_pkg::REG_INT_ZONE:     int_zone_q     <= wr_data[DATA_WIDTH-1:0];
				pidz_pkg::REG_SETTLE_BAND:  settle_band_q  <= wr_data[DATA_WIDTH-1:0];
				pidz_pkg::REG_SETTLE_TICKS: settle_ticks_q <= wr_data[COUNT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// A stage may load when empty or when its content moves on.
	assign rdy_out      = !out_valid_q || result.ready;
	assign rdy3         = !valid_s3 || rdy_out;
	assign rdy2         = !valid_s2 || rdy3;
	assign rdy1         = !valid_s1 || rdy2;
	assign adv1         = valid_s1 && rdy2;
	assign sample.ready = rdy1;
	assign ctl.load_s3  = valid_s2 && rdy3;
	assign ctl.load_out = valid_s3 && rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= sample.valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy_out) out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && rdy1) begin
			meas_s1 <= sample.measured_value;
		end
	end

	// Error stage: error, derivative, integral and settle counter.
	always_comb begin
		err   = EW'(setpoint_q) - EW'(meas_s1);
		deriv = (EW+1)'(err) - (EW+1)'(prev_err_q);
		mag   = err[EW-1] ? (~err + 1'b1) : err;

		isum = SW'(integ_q) + SW'(err);
		if (isum > AMAX) begin
			integ_sat = AMAX[ACC_WIDTH-1:0];
		end else if (isum < AMIN) begin
			integ_sat = AMIN[ACC_WIDTH-1:0];
		end else begin
			integ_sat = isum[ACC_WIDTH-1:0];
		end

		// Three-valued sign: negative, zero, positive.
		sign_chg = (err[EW-1] != prev_err_q[EW-1]) || ((err == '0) != (prev_err_q == '0));

		priority if (gains_q.i == '0) begin
			integ_next = integ_q;
		end else if (sign_chg) begin
			integ_next = '0;
		end else if (mag < {1'b0, int_zone_q}) begin
			integ_next = integ_sat;
		end else begin
			integ_next = integ_q;
		end

		if (mag < {1'b0, settle_band_q} && settle_count_q != '1) begin
			count_next = settle_count_q + 1'b1;
		end else begin
			count_next = settle_count_q;
		end
		settled = count_next > settle_ticks_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q     <= '0;
			integ_q        <= '0;
			settle_count_q <= '0;
		end else if (adv1) begin
			prev_err_q     <= err;
			integ_q        <= integ_next;
			settle_count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			err_s2     <= err;
			deriv_s2   <= deriv;
			integ_s2   <= integ_next;
			settled_s2 <= settled;
		end
		if (ctl.load_s3) begin
			err_s3     <= err_s2;
			settled_s3 <= settled_s2;
		end
		if (ctl.load_out) begin
			error_now_q <= err_s3;
			settled_q   <= settled_s3;
		end
	end

	pidz_drive #(
		.DATA_WIDTH     (DATA_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.ACC_WIDTH      (ACC_WIDTH)
	) u_drive (
		.clk      (clk),
		.ctl      (ctl),
		.gains    (gains_q),
		.err_s2   (err_s2),
		.deriv_s2 (deriv_s2),
		.integ_s2 (integ_s2),
		.drive_q  (result.drive)
	);

	assign result.valid     = out_valid_q;
	assign result.error_now = error_now_q;
	assign result.settled   = settled_q;

	`PIDZ_ASSERT_NEXT(a_count_mono, 1'b1, settle_count_q >= $past(settle_count_q), "settle count decreased")
	`PIDZ_ASSERT_NEXT(a_integ_frozen, adv1 && gains_q.i == '0, $stable(integ_q), "integral moved with zero I gain")
	`PIDZ_ASSERT_NEXT(a_integ_clear, adv1 && gains_q.i != '0 && sign_chg, integ_q == '0, "integral not cleared on sign change")

endmodule
